[rtl/bfr_pkg.sv]
// Package for the boundary flux residual block: payload, register and
// microcode types, fixed-point constants and the sequencer microprogram.
// No dependencies.
package bfr_pkg;

   localparam int unsigned CELLS_DEF = 1024;
   localparam int unsigned IDX_W     = 10;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PC_W      = 7;
   localparam int unsigned CSR_IDX_W = 3;

   // One half in Q11.20.
   localparam logic signed [DATA_W-1:0] Q_HALF = 32'sd524288;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_GAMMA_M1  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DISS_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_RHO  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_MX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_MY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FREE_E    = 3'd5;

   typedef struct packed {
      logic signed [31:0] node_a_x;
      logic signed [31:0] node_a_y;
      logic signed [31:0] node_b_x;
      logic signed [31:0] node_b_y;
      logic        [30:0] cell_density;
      logic signed [31:0] cell_momentum_x;
      logic signed [31:0] cell_momentum_y;
      logic signed [31:0] cell_energy;
      logic signed [31:0] step_factor;
      logic               wall_edge;
      logic        [9:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic        [9:0]  out_cell;
      logic signed [31:0] residual_mass;
      logic signed [31:0] residual_mom_x;
      logic signed [31:0] residual_mom_y;
      logic signed [31:0] residual_energy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] gamma_minus_one;
      logic signed [31:0] dissipation_gain;
      logic        [30:0] free_density;
      logic signed [31:0] free_momentum_x;
      logic signed [31:0] free_momentum_y;
      logic signed [31:0] free_energy;
   } cfg_type;

   typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB} op_type;

   typedef enum logic [4:0] {
      SRC_AX, SRC_AY, SRC_BX, SRC_BY, SRC_Q0, SRC_Q1, SRC_Q2, SRC_Q3, SRC_ADT,
      SRC_GM1, SRC_EPS, SRC_FD, SRC_FMX, SRC_FMY, SRC_FE, SRC_HALF, SRC_RI,
      SRC_RI2, SRC_DX, SRC_DY, SRC_TA, SRC_TB, SRC_P1, SRC_V1, SRC_P2, SRC_V2,
      SRC_MU, SRC_R0, SRC_R1, SRC_R2, SRC_R3
   } src_type;

   typedef enum logic [3:0] {
      DST_DX, DST_DY, DST_TA, DST_TB, DST_P1, DST_V1, DST_P2, DST_V2, DST_MU,
      DST_R0, DST_R1, DST_R2, DST_R3
   } dst_type;

   // What follows a micro-op: the next one, a wall/far-field branch, or the end.
   typedef enum logic [1:0] {NX_STEP, NX_BRANCH, NX_END} next_type;

   typedef struct packed {
      op_type   op;
      src_type  src_a;
      src_type  src_b;
      dst_type  dst;
      next_type nxt;
   } uop_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_REDUCE, ST_READ, ST_LOAD, ST_RQ0, ST_WQ0, ST_RFD, ST_WFD,
      ST_EXEC, ST_WRITE
   } state_type;

   localparam logic [PC_W-1:0] PC_WALL = 7'd9;
   localparam logic [PC_W-1:0] PC_FAR  = 7'd13;

   function automatic uop_type mk(op_type op, src_type a, src_type b, dst_type d,
                                  next_type n);
      mk = '{op: op, src_a: a, src_b: b, dst: d, nxt: n};
   endfunction

   // Microprogram. The common part forms the edge vector and the cell
   // pressure, then branches to the wall or far-field sequence.
   function automatic uop_type uop_rom(logic [PC_W-1:0] pc);
      unique case (pc)
         7'd0:  uop_rom = mk(OP_SUB, SRC_AX,   SRC_BX,  DST_DX, NX_STEP);
         7'd1:  uop_rom = mk(OP_SUB, SRC_AY,   SRC_BY,  DST_DY, NX_STEP);
         7'd2:  uop_rom = mk(OP_MUL, SRC_Q1,   SRC_Q1,  DST_TA, NX_STEP);
         7'd3:  uop_rom = mk(OP_MUL, SRC_Q2,   SRC_Q2,  DST_TB, NX_STEP);
         7'd4:  uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd5:  uop_rom = mk(OP_MUL, SRC_HALF, SRC_RI,  DST_TB, NX_STEP);
         7'd6:  uop_rom = mk(OP_MUL, SRC_TB,   SRC_TA,  DST_TA, NX_STEP);
         7'd7:  uop_rom = mk(OP_SUB, SRC_Q3,   SRC_TA,  DST_TA, NX_STEP);
         7'd8:  uop_rom = mk(OP_MUL, SRC_GM1,  SRC_TA,  DST_P1, NX_BRANCH);
         // Wall edge: pressure flux only.
         7'd9:  uop_rom = mk(OP_MUL, SRC_P1,   SRC_DY,  DST_TA, NX_STEP);
         7'd10: uop_rom = mk(OP_ADD, SRC_R1,   SRC_TA,  DST_R1, NX_STEP);
         7'd11: uop_rom = mk(OP_MUL, SRC_P1,   SRC_DX,  DST_TA, NX_STEP);
         7'd12: uop_rom = mk(OP_SUB, SRC_R2,   SRC_TA,  DST_R2, NX_END);
         // Far field: cell volume flux.
         7'd13: uop_rom = mk(OP_MUL, SRC_Q1,   SRC_DY,  DST_TA, NX_STEP);
         7'd14: uop_rom = mk(OP_MUL, SRC_Q2,   SRC_DX,  DST_TB, NX_STEP);
         7'd15: uop_rom = mk(OP_SUB, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd16: uop_rom = mk(OP_MUL, SRC_RI,   SRC_TA,  DST_V1, NX_STEP);
         // Free-stream pressure.
         7'd17: uop_rom = mk(OP_MUL, SRC_FMX,  SRC_FMX, DST_TA, NX_STEP);
         7'd18: uop_rom = mk(OP_MUL, SRC_FMY,  SRC_FMY, DST_TB, NX_STEP);
         7'd19: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd20: uop_rom = mk(OP_MUL, SRC_HALF, SRC_RI2, DST_TB, NX_STEP);
         7'd21: uop_rom = mk(OP_MUL, SRC_TB,   SRC_TA,  DST_TA, NX_STEP);
         7'd22: uop_rom = mk(OP_SUB, SRC_FE,   SRC_TA,  DST_TA, NX_STEP);
         7'd23: uop_rom = mk(OP_MUL, SRC_GM1,  SRC_TA,  DST_P2, NX_STEP);
         // Free-stream volume flux and dissipation factor.
         7'd24: uop_rom = mk(OP_MUL, SRC_FMX,  SRC_DY,  DST_TA, NX_STEP);
         7'd25: uop_rom = mk(OP_MUL, SRC_FMY,  SRC_DX,  DST_TB, NX_STEP);
         7'd26: uop_rom = mk(OP_SUB, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd27: uop_rom = mk(OP_MUL, SRC_RI2,  SRC_TA,  DST_V2, NX_STEP);
         7'd28: uop_rom = mk(OP_MUL, SRC_ADT,  SRC_EPS, DST_MU, NX_STEP);
         // Mass.
         7'd29: uop_rom = mk(OP_MUL, SRC_V1,   SRC_Q0,  DST_TA, NX_STEP);
         7'd30: uop_rom = mk(OP_MUL, SRC_V2,   SRC_FD,  DST_TB, NX_STEP);
         7'd31: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd32: uop_rom = mk(OP_MUL, SRC_HALF, SRC_TA,  DST_TA, NX_STEP);
         7'd33: uop_rom = mk(OP_SUB, SRC_Q0,   SRC_FD,  DST_TB, NX_STEP);
         7'd34: uop_rom = mk(OP_MUL, SRC_MU,   SRC_TB,  DST_TB, NX_STEP);
         7'd35: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd36: uop_rom = mk(OP_ADD, SRC_R0,   SRC_TA,  DST_R0, NX_STEP);
         // X momentum.
         7'd37: uop_rom = mk(OP_MUL, SRC_V1,   SRC_Q1,  DST_TA, NX_STEP);
         7'd38: uop_rom = mk(OP_MUL, SRC_P1,   SRC_DY,  DST_TB, NX_STEP);
         7'd39: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd40: uop_rom = mk(OP_MUL, SRC_V2,   SRC_FMX, DST_TB, NX_STEP);
         7'd41: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd42: uop_rom = mk(OP_MUL, SRC_P2,   SRC_DY,  DST_TB, NX_STEP);
         7'd43: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd44: uop_rom = mk(OP_MUL, SRC_HALF, SRC_TA,  DST_TA, NX_STEP);
         7'd45: uop_rom = mk(OP_SUB, SRC_Q1,   SRC_FMX, DST_TB, NX_STEP);
         7'd46: uop_rom = mk(OP_MUL, SRC_MU,   SRC_TB,  DST_TB, NX_STEP);
         7'd47: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd48: uop_rom = mk(OP_ADD, SRC_R1,   SRC_TA,  DST_R1, NX_STEP);
         // Y momentum.
         7'd49: uop_rom = mk(OP_MUL, SRC_V1,   SRC_Q2,  DST_TA, NX_STEP);
         7'd50: uop_rom = mk(OP_MUL, SRC_P1,   SRC_DX,  DST_TB, NX_STEP);
         7'd51: uop_rom = mk(OP_SUB, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd52: uop_rom = mk(OP_MUL, SRC_V2,   SRC_FMY, DST_TB, NX_STEP);
         7'd53: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd54: uop_rom = mk(OP_MUL, SRC_P2,   SRC_DX,  DST_TB, NX_STEP);
         7'd55: uop_rom = mk(OP_SUB, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd56: uop_rom = mk(OP_MUL, SRC_HALF, SRC_TA,  DST_TA, NX_STEP);
         7'd57: uop_rom = mk(OP_SUB, SRC_Q2,   SRC_FMY, DST_TB, NX_STEP);
         7'd58: uop_rom = mk(OP_MUL, SRC_MU,   SRC_TB,  DST_TB, NX_STEP);
         7'd59: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd60: uop_rom = mk(OP_ADD, SRC_R2,   SRC_TA,  DST_R2, NX_STEP);
         // Energy.
         7'd61: uop_rom = mk(OP_ADD, SRC_Q3,   SRC_P1,  DST_TA, NX_STEP);
         7'd62: uop_rom = mk(OP_MUL, SRC_V1,   SRC_TA,  DST_TA, NX_STEP);
         7'd63: uop_rom = mk(OP_ADD, SRC_FE,   SRC_P2,  DST_TB, NX_STEP);
         7'd64: uop_rom = mk(OP_MUL, SRC_V2,   SRC_TB,  DST_TB, NX_STEP);
         7'd65: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd66: uop_rom = mk(OP_MUL, SRC_HALF, SRC_TA,  DST_TA, NX_STEP);
         7'd67: uop_rom = mk(OP_SUB, SRC_Q3,   SRC_FE,  DST_TB, NX_STEP);
         7'd68: uop_rom = mk(OP_MUL, SRC_MU,   SRC_TB,  DST_TB, NX_STEP);
         7'd69: uop_rom = mk(OP_ADD, SRC_TA,   SRC_TB,  DST_TA, NX_STEP);
         7'd70: uop_rom = mk(OP_ADD, SRC_R3,   SRC_TA,  DST_R3, NX_END);
         default: uop_rom = mk(OP_ADD, SRC_TA, SRC_TB,  DST_TA, NX_END);
      endcase
   endfunction

endpackage

[rtl/boundary_flux_residual.sv]
// Boundary flux residual: one edge beat in, one updated residual beat out.
// The index is reduced by subtracting CELLS, residuals read, two reciprocals formed
// and the microprogram run; a result stall holds the write-back. The next edge can
// be taken in the cycle after the result beat is issued. Reset clears the control
// state and starts a clearing pass over all CELLS memory entries, during which no
// edge is accepted; configuration writes are taken as ever.
module boundary_flux_residual #(
   parameter int unsigned CELLS = bfr_pkg::CELLS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bfr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bfr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [bfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfr_pkg::DATA_W-1:0]        csr_wr_data
);
   import bfr_pkg::*;

   localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   cfg_type            cfg_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;
   uop_type            uop;
   logic               mem_busy, mem_rd, mem_we;
   logic [127:0]       mem_rdata;
   logic               exec, load_res, load_ri, load_ri2, rcp_start, rcp_done;
   logic [30:0]        rcp_div;
   logic [31:0]        rcp_q;
   logic signed [31:0] res0, res1, res2, res3;
   logic               req_take, rsp_free;

   assign uop      = uop_rom(pc_ff);
   assign req_take = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gamma_minus_one  <= 32'sd419430;
         cfg_ff.dissipation_gain <= 32'sd52429;
         cfg_ff.free_density     <= 31'd1048576;
         cfg_ff.free_momentum_x  <= '0;
         cfg_ff.free_momentum_y  <= '0;
         cfg_ff.free_energy      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_GAMMA_M1:  cfg_ff.gamma_minus_one  <= csr_wr_data;
            REG_DISS_GAIN: cfg_ff.dissipation_gain <= csr_wr_data;
            REG_FREE_RHO:  cfg_ff.free_density     <= csr_wr_data[30:0];
            REG_FREE_MX:   cfg_ff.free_momentum_x  <= csr_wr_data;
            REG_FREE_MY:   cfg_ff.free_momentum_y  <= csr_wr_data;
            REG_FREE_E:    cfg_ff.free_energy      <= csr_wr_data;
            default:       cfg_ff.free_energy      <= cfg_ff.free_energy;
         endcase
      end
   end

   // Sequencer: reduce the index, fetch residuals, two reciprocals, microprogram.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      mem_rd       = 1'b0;
      mem_we       = 1'b0;
      exec         = 1'b0;
      load_res     = 1'b0;
      load_ri      = 1'b0;
      load_ri2     = 1'b0;
      rcp_start    = 1'b0;
      rcp_div      = item_ff.cell_density;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !mem_busy;
            if (req_take) begin
               item_in  = req_data;
               idx_in   = req_data.cell_index;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (17'(idx_ff) >= 17'(CELLS)) begin
               idx_in = idx_ff - IDX_W'(CELLS);
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            load_res = 1'b1;
            state_in = ST_RQ0;
         end
         ST_RQ0: begin
            rcp_start = 1'b1;
            state_in  = ST_WQ0;
         end
         ST_WQ0: begin
            if (rcp_done) begin
               load_ri  = 1'b1;
               state_in = ST_RFD;
            end
         end
         ST_RFD: begin
            rcp_start = 1'b1;
            rcp_div   = cfg_ff.free_density;
            state_in  = ST_WFD;
         end
         ST_WFD: begin
            if (rcp_done) begin
               load_ri2 = 1'b1;
               pc_in    = '0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            exec = 1'b1;
            unique case (uop.nxt)
               NX_STEP:   pc_in = pc_ff + PC_W'(1);
               NX_BRANCH: pc_in = item_ff.wall_edge ? PC_WALL : PC_FAR;
               NX_END:    state_in = ST_WRITE;
               default:   state_in = ST_WRITE;
            endcase
         end
         ST_WRITE: begin
            if (rsp_free) begin
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      idx_ff  <= idx_in;
      pc_ff   <= pc_in;
      if (mem_we) begin
         rsp_ff <= '{out_cell: idx_ff, residual_mass: res0, residual_mom_x: res1,
                     residual_mom_y: res2, residual_energy: res3};
      end
   end

   bfr_store #(.CELLS(CELLS), .AW(AW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd),
      .rd_addr (AW'(idx_ff)),
      .rd_data (mem_rdata),
      .wr_en   (mem_we),
      .wr_addr (AW'(idx_ff)),
      .wr_data ({res3, res2, res1, res0}),
      .busy    (mem_busy)
   );

   bfr_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (rcp_start),
      .divisor  (rcp_div),
      .done     (rcp_done),
      .quotient (rcp_q)
   );

   bfr_datapath u_datapath (
      .clock    (clock),
      .item     (item_ff),
      .cfg      (cfg_ff),
      .exec     (exec),
      .uop      (uop),
      .load_res (load_res),
      .res_load (mem_rdata),
      .load_ri  (load_ri),
      .load_ri2 (load_ri2),
      .recip    (rcp_q),
      .res0     (res0),
      .res1     (res1),
      .res2     (res2),
      .res3     (res3)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // No edge is taken while the clearing pass still runs.
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !mem_busy)
      else $error("edge accepted during memory clear");

   // A residual write-back never overwrites an unread result beat.
   a_write_when_free: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> rsp_free)
      else $error("result overwritten before it was taken");

   // A reciprocal finishes only while the sequencer waits for it.
   a_recip_done_wait: assert property (@(posedge clock) disable iff (reset)
      rcp_done |-> (state_ff == ST_WQ0 || state_ff == ST_WFD))
      else $error("reciprocal finished outside a wait state");

   // An accepted edge always leaves the idle state.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != ST_IDLE)
      else $error("accepted edge not started");

endmodule

[rtl/bfr_recip.sv]
// Restoring radix-2 reciprocal unit: floor(2^40 / d), saturated to 2^31-1.
// Uses bfr_pkg.
module bfr_recip (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import bfr_pkg::*;

   localparam int unsigned Q_W = 41;
   localparam logic [5:0] TOP_BIT = 6'(Q_W - 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [31:0]    rem_ff, rem_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [30:0]    div_ff, div_in;
   logic [31:0]    trial;
   logic           fits;

   // One quotient bit per cycle; the dividend has only its top bit set.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      trial   = {rem_ff[30:0], (cnt_ff == TOP_BIT)};
      fits    = trial >= {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = TOP_BIT;
         rem_in  = '0;
         q_in    = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? trial - {1'b0, div_ff} : trial;
         q_in   = {q_ff[Q_W-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   // A zero divisor or a quotient beyond 31 bits saturates.
   assign done     = done_ff;
   assign quotient = (div_ff == '0 || q_ff[Q_W-1:31] != '0) ? 32'h7FFF_FFFF
                                                           : {1'b0, q_ff[30:0]};

endmodule

[rtl/bfr_store.sv]
// Per-cell residual memory, four residuals per word, with a clearing pass
// after reset. Uses bfr_pkg.
module bfr_store #(
   parameter int unsigned CELLS = bfr_pkg::CELLS_DEF,
   parameter int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [127:0]  rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [127:0]  wr_data,
   output logic          busy
);
   import bfr_pkg::*;

   localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

   logic [127:0]  mem [CELLS];
   logic [127:0]  rd_ff;
   logic          clr_ff, clr_in;
   logic [AW-1:0] cnt_ff, cnt_in;

   // Clearing pass walks one entry per cycle.
   always_comb begin
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      if (clr_ff) begin
         cnt_in = cnt_ff + AW'(1);
         if (cnt_ff == LAST) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         cnt_ff <= '0;
      end else begin
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
      end
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[cnt_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
   assign busy    = clr_ff;

endmodule

[rtl/bfr_datapath.sv]
// Operand registers and the shared saturating multiply/add unit driven by
// the microprogram. Uses bfr_pkg.
module bfr_datapath (
   input  logic                       clock,
   input  bfr_pkg::req_type           item,
   input  bfr_pkg::cfg_type           cfg,
   input  logic                       exec,
   input  bfr_pkg::uop_type           uop,
   input  logic                       load_res,
   input  logic [127:0]               res_load,
   input  logic                       load_ri,
   input  logic                       load_ri2,
   input  logic signed [31:0]         recip,
   output logic signed [31:0]         res0,
   output logic signed [31:0]         res1,
   output logic signed [31:0]         res2,
   output logic signed [31:0]         res3
);
   import bfr_pkg::*;

   localparam logic signed [63:0] MAX64 = 64'sd2147483647;
   localparam logic signed [63:0] MIN64 = -64'sd2147483648;
   localparam logic signed [63:0] RND   = 64'sd524288;

   logic signed [31:0] dx_ff, dy_ff, ta_ff, tb_ff, p1_ff, v1_ff, p2_ff, v2_ff, mu_ff;
   logic signed [31:0] ri_ff, ri2_ff, r0_ff, r1_ff, r2_ff, r3_ff;
   logic signed [31:0] a, b, y;
   logic signed [63:0] prod, rnd, sh;
   logic signed [32:0] sum;

   function automatic logic signed [31:0] pick(src_type s, req_type it, cfg_type c,
         logic signed [31:0] dx, logic signed [31:0] dy, logic signed [31:0] ta,
         logic signed [31:0] tb, logic signed [31:0] p1, logic signed [31:0] v1,
         logic signed [31:0] p2, logic signed [31:0] v2, logic signed [31:0] mu,
         logic signed [31:0] ri, logic signed [31:0] ri2, logic signed [31:0] r0,
         logic signed [31:0] r1, logic signed [31:0] r2, logic signed [31:0] r3);
      unique case (s)
         SRC_AX:   pick = it.node_a_x;
         SRC_AY:   pick = it.node_a_y;
         SRC_BX:   pick = it.node_b_x;
         SRC_BY:   pick = it.node_b_y;
         SRC_Q0:   pick = {1'b0, it.cell_density};
         SRC_Q1:   pick = it.cell_momentum_x;
         SRC_Q2:   pick = it.cell_momentum_y;
         SRC_Q3:   pick = it.cell_energy;
         SRC_ADT:  pick = it.step_factor;
         SRC_GM1:  pick = c.gamma_minus_one;
         SRC_EPS:  pick = c.dissipation_gain;
         SRC_FD:   pick = {1'b0, c.free_density};
         SRC_FMX:  pick = c.free_momentum_x;
         SRC_FMY:  pick = c.free_momentum_y;
         SRC_FE:   pick = c.free_energy;
         SRC_HALF: pick = Q_HALF;
         SRC_RI:   pick = ri;
         SRC_RI2:  pick = ri2;
         SRC_DX:   pick = dx;
         SRC_DY:   pick = dy;
         SRC_TA:   pick = ta;
         SRC_TB:   pick = tb;
         SRC_P1:   pick = p1;
         SRC_V1:   pick = v1;
         SRC_P2:   pick = p2;
         SRC_V2:   pick = v2;
         SRC_MU:   pick = mu;
         SRC_R0:   pick = r0;
         SRC_R1:   pick = r1;
         SRC_R2:   pick = r2;
         SRC_R3:   pick = r3;
         default:  pick = '0;
      endcase
   endfunction

   // Operand selection.
   always_comb begin
      a = pick(uop.src_a, item, cfg, dx_ff, dy_ff, ta_ff, tb_ff, p1_ff, v1_ff,
               p2_ff, v2_ff, mu_ff, ri_ff, ri2_ff, r0_ff, r1_ff, r2_ff, r3_ff);
      b = pick(uop.src_b, item, cfg, dx_ff, dy_ff, ta_ff, tb_ff, p1_ff, v1_ff,
               p2_ff, v2_ff, mu_ff, ri_ff, ri2_ff, r0_ff, r1_ff, r2_ff, r3_ff);
   end

   // Shared unit: rounded Q11.20 product or sum/difference, all saturated.
   always_comb begin
      prod = 64'(a) * 64'(b);
      rnd  = prod + RND;
      sh   = rnd >>> 20;
      sum  = (uop.op == OP_SUB) ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      unique case (uop.op)
         OP_MUL: begin
            if (sh > MAX64) begin
               y = 32'sh7FFF_FFFF;
            end else if (sh < MIN64) begin
               y = -32'sh8000_0000;
            end else begin
               y = sh[31:0];
            end
         end
         OP_ADD, OP_SUB: begin
            if (sum[32] != sum[31]) begin
               y = sum[32] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               y = sum[31:0];
            end
         end
         default: y = '0;
      endcase
   end

   // Result write-back and residual/reciprocal loads.
   always_ff @(posedge clock) begin
      if (load_ri) begin
         ri_ff <= recip;
      end
      if (load_ri2) begin
         ri2_ff <= recip;
      end
      if (load_res) begin
         r0_ff <= res_load[31:0];
         r1_ff <= res_load[63:32];
         r2_ff <= res_load[95:64];
         r3_ff <= res_load[127:96];
      end else if (exec) begin
         unique case (uop.dst)
            DST_DX:  dx_ff <= y;
            DST_DY:  dy_ff <= y;
            DST_TA:  ta_ff <= y;
            DST_TB:  tb_ff <= y;
            DST_P1:  p1_ff <= y;
            DST_V1:  v1_ff <= y;
            DST_P2:  p2_ff <= y;
            DST_V2:  v2_ff <= y;
            DST_MU:  mu_ff <= y;
            DST_R0:  r0_ff <= y;
            DST_R1:  r1_ff <= y;
            DST_R2:  r2_ff <= y;
            DST_R3:  r3_ff <= y;
            default: ta_ff <= ta_ff;
         endcase
      end
   end

   assign res0 = r0_ff;
   assign res1 = r1_ff;
   assign res2 = r2_ff;
   assign res3 = r3_ff;

endmodule
